// ===== sv/anchored_adapter_trimmer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the anchored adapter trimmer
// Concurrent checks on the rising clock edge, held off during reset.
// Simulation builds get the checks; synthesis builds get empty bodies.
// ---------------------------------------------------------------------------
`ifndef ANCHORED_ADAPTER_TRIMMER_UNIT_DEFINES_SVH
`define ANCHORED_ADAPTER_TRIMMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define AAT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define AAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AAT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define AAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/aat_pkg.sv =====
// ---------------------------------------------------------------------------
// Anchored adapter trimmer package
// Sizes, register indexes and item types shared by the trimmer files.
// ---------------------------------------------------------------------------
package aat_pkg;

  // Sizing
  localparam int MAX_ADAPTER_LEN = 16;
  localparam int NUM_ADAPTERS    = 2;
  localparam int LENGTH_BITS     = 16;
  localparam int REG_BYTES       = 16;
  localparam int COUNT_BITS      = $clog2(MAX_ADAPTER_LEN + 1);
  localparam int ADP_VEC_BITS    =
    ((MAX_ADAPTER_LEN > REG_BYTES) ? MAX_ADAPTER_LEN : REG_BYTES) * 8;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int ALEN_BITS      = 5;
  localparam int MO_BITS        = 5;
  localparam int MM_BITS        = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FIRST_LOW   = 3'd0,
    REG_FIRST_HIGH  = 3'd1,
    REG_SECOND_LOW  = 3'd2,
    REG_SECOND_HIGH = 3'd3,
    REG_FIRST_LEN   = 3'd4,
    REG_SECOND_LEN  = 3'd5,
    REG_MIN_OVERLAP = 3'd6,
    REG_MAX_MISMATCH = 3'd7
  } reg_index_t;

  // One read base
  typedef struct packed {
    logic [7:0] base;
    logic       last_base;
  } base_item_t;

  // One trim result
  typedef struct packed {
    logic [LENGTH_BITS-1:0] keep_length;
    logic                   trimmed;
    logic                   matched_adapter;
    logic [LENGTH_BITS-1:0] read_length;
    logic                   length_overflow;
    logic                   config_error;
  } result_item_t;

endpackage

// ===== sv/aat_base_if.sv =====
// ---------------------------------------------------------------------------
// Base channel
// Valid/ready channel carrying one read base per item.
// ---------------------------------------------------------------------------
interface aat_base_if;
  logic                valid;
  logic                ready;
  aat_pkg::base_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/aat_result_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one trim result per item.
// ---------------------------------------------------------------------------
interface aat_result_if;
  logic                  valid;
  logic                  ready;
  aat_pkg::result_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/anchored_adapter_trimmer_unit.sv =====
// ---------------------------------------------------------------------------
// Anchored adapter trimmer
// Counts the bases of a read, keeps the newest bases in a window and, at the
// read end, searches both adapters for the earliest 3' overlap match.
//
//   channel  | dir | payload                                      | handshake
//   bases    | in  | base, last_base                              | valid/ready
//   results  | out | keep_length, trimmed, matched_adapter,       | valid/ready
//            |     | read_length, length_overflow, config_error   |
//   cfg      | in  | cfg_index, cfg_data                          | cfg_write
//
// A base that is not last shifts into the window. A last base starts the
// scan, after which the result register is loaded: the single mismatch-count
// unit tests one adapter at one overlap per cycle, longest overlap first,
// and stops at the first match.
// A config error or a length overflow skips the scan.
// The block takes no base while scanning or loading a result; a result left
// waiting in the output register does not stop bases of the next read.
// Synchronous reset clears control state and the base window.
// ---------------------------------------------------------------------------
`include "anchored_adapter_trimmer_unit_defines.svh"

module anchored_adapter_trimmer_unit (
  input  logic                                clk,
  input  logic                                rst,
  aat_base_if.sink                            bases,
  aat_result_if.source                        results,
  input  logic                                cfg_write,
  input  logic [aat_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [aat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int MAXL = aat_pkg::MAX_ADAPTER_LEN;
  localparam int LB   = aat_pkg::LENGTH_BITS;
  localparam int CB   = aat_pkg::COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Adapter bytes, position 0 in the low byte; positions past the registers are zero
  function automatic logic [MAXL*8-1:0] adapter_vec(
    input logic [aat_pkg::CFG_DATA_BITS-1:0] lo,
    input logic [aat_pkg::CFG_DATA_BITS-1:0] hi
  );
    logic [aat_pkg::ADP_VEC_BITS-1:0] v;
    v = aat_pkg::ADP_VEC_BITS'({hi, lo});
    return v[MAXL*8-1:0];
  endfunction

  // Saturate a configured adapter length to the window depth
  function automatic logic [CB-1:0] sat_len(input logic [aat_pkg::ALEN_BITS-1:0] len);
    logic [LB-1:0] wide;
    wide = LB'(len);
    return (wide > LB'(MAXL)) ? CB'(MAXL) : CB'(len);
  endfunction

  // Configuration registers
  logic [aat_pkg::CFG_DATA_BITS-1:0] first_low, first_high, second_low, second_high;
  logic [aat_pkg::ALEN_BITS-1:0]     first_len, second_len;
  logic [aat_pkg::MO_BITS-1:0]       min_overlap;
  logic [aat_pkg::MM_BITS-1:0]       max_mismatches;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_low      <= '0;
      first_high     <= '0;
      second_low     <= '0;
      second_high    <= '0;
      first_len      <= '0;
      second_len     <= '0;
      min_overlap    <= aat_pkg::MO_BITS'(3);
      max_mismatches <= '0;
    end else if (cfg_write) begin
      case (aat_pkg::reg_index_t'(cfg_index))
        aat_pkg::REG_FIRST_LOW:    first_low      <= cfg_data;
        aat_pkg::REG_FIRST_HIGH:   first_high     <= cfg_data;
        aat_pkg::REG_SECOND_LOW:   second_low     <= cfg_data;
        aat_pkg::REG_SECOND_HIGH:  second_high    <= cfg_data;
        aat_pkg::REG_FIRST_LEN:    first_len      <= cfg_data[aat_pkg::ALEN_BITS-1:0];
        aat_pkg::REG_SECOND_LEN:   second_len     <= cfg_data[aat_pkg::ALEN_BITS-1:0];
        aat_pkg::REG_MIN_OVERLAP:  min_overlap    <= cfg_data[aat_pkg::MO_BITS-1:0];
        aat_pkg::REG_MAX_MISMATCH: max_mismatches <= cfg_data[aat_pkg::MM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings
  logic [aat_pkg::MO_BITS-1:0] mo_eff;
  logic                        cfg_err_now;
  logic [MAXL*8-1:0]           adp0_vec, adp1_vec;
  logic [CB-1:0]               alen0, alen1;

  assign mo_eff      = (min_overlap == '0) ? aat_pkg::MO_BITS'(1) : min_overlap;
  assign cfg_err_now = aat_pkg::MO_BITS'(max_mismatches) >= mo_eff;
  assign adp0_vec    = adapter_vec(first_low, first_high);
  assign adp1_vec    = adapter_vec(second_low, second_high);
  assign alen0       = sat_len(first_len);
  assign alen1       = sat_len(second_len);

  // Control and scan registers
  state_t            state;
  logic [7:0]        win [MAXL];      // index 0 = newest base
  logic [7:0]        aligned [MAXL];  // aligned[k] faces adapter byte k
  logic [LB-1:0]     length_count, count_next;
  logic              count_overflowed, ovf_next;
  logic [LB-1:0]     read_len, keep;
  logic              ovf_lat, cfg_err_lat, found, which;
  logic [CB-1:0]     ov;
  logic              adp;
  logic              res_valid;
  aat_pkg::result_item_t res_item;

  logic base_acc, last_acc, load_res;

  assign base_acc = bases.valid && bases.ready;
  assign last_acc = base_acc && bases.item.last_base;
  assign load_res = (state == S_DONE) && (!res_valid || results.ready);

  assign bases.ready   = (state == S_IDLE);
  assign results.valid = res_valid;
  assign results.item  = res_item;

  // Saturating length count
  always_comb begin
    if (length_count == '1) begin
      count_next = length_count;
      ovf_next   = 1'b1;
    end else begin
      count_next = length_count + LB'(1);
      ovf_next   = count_overflowed;
    end
  end

  // Shared mismatch-count unit: one adapter at one overlap
  logic [MAXL*8-1:0] sel_vec;
  logic [CB-1:0]     sel_alen, mis;
  logic              cand_ok, hit, last_adp, scan_end;

  assign sel_vec  = adp ? adp1_vec : adp0_vec;
  assign sel_alen = adp ? alen1 : alen0;

  always_comb begin
    mis = '0;
    for (int k = 0; k < MAXL; k++) begin
      if ((CB'(k) < ov) && (aligned[k] != sel_vec[k*8 +: 8])) begin
        mis = mis + CB'(1);
      end
    end
  end

  assign cand_ok  = (LB'(ov) >= LB'(mo_eff)) && (LB'(ov) <= read_len) && (ov <= sel_alen);
  assign hit      = cand_ok && (LB'(mis) <= LB'(max_mismatches));
  assign last_adp = (adp == 1'(aat_pkg::NUM_ADAPTERS - 1));
  assign scan_end = last_adp && (LB'(ov) <= LB'(mo_eff));

  // Base window and length count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAXL; j++) win[j] <= '0;
      length_count     <= '0;
      count_overflowed <= 1'b0;
    end else if (base_acc) begin
      if (bases.item.last_base) begin
        for (int j = 0; j < MAXL; j++) win[j] <= '0;
        length_count     <= '0;
        count_overflowed <= 1'b0;
      end else begin
        win[0] <= bases.item.base;
        for (int j = 1; j < MAXL; j++) win[j] <= win[j-1];
        length_count     <= count_next;
        count_overflowed <= ovf_next;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (last_acc) begin
            state <= (cfg_err_now || ovf_next) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit || scan_end) state <= S_DONE;
        end
        S_DONE: begin
          if (load_res) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (last_acc) begin
      // Window after this base, reversed so that the longest overlap lines up
      aligned[MAXL-1] <= bases.item.base;
      for (int k = 0; k < MAXL-1; k++) aligned[k] <= win[MAXL-2-k];
      read_len    <= count_next;
      keep        <= count_next;
      ovf_lat     <= ovf_next;
      cfg_err_lat <= cfg_err_now;
      found       <= 1'b0;
      which       <= 1'b0;
      ov          <= CB'(MAXL);
      adp         <= 1'b0;
    end else if (state == S_SCAN) begin
      if (hit) begin
        found <= 1'b1;
        which <= adp;
        keep  <= read_len - LB'(ov);
      end else if (last_adp) begin
        // Next shorter overlap: slide the window by one base
        ov  <= ov - CB'(1);
        adp <= 1'b0;
        for (int k = 0; k < MAXL-1; k++) aligned[k] <= aligned[k+1];
        aligned[MAXL-1] <= '0;
      end else begin
        adp <= ~adp;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_item.keep_length     <= keep;
      res_item.trimmed         <= found;
      res_item.matched_adapter <= which;
      res_item.read_length     <= read_len;
      res_item.length_overflow <= ovf_lat;
      res_item.config_error    <= cfg_err_lat;
    end
  end

  // Checks
  `AAT_ASSERT_NEXT(a_last_starts_scan, clk, rst, last_acc, state == S_SCAN || state == S_DONE, "last base did not start the search")
  `AAT_ASSERT_IMPLY(a_scan_overlap_nonzero, clk, rst, state == S_SCAN, ov != '0, "scan reached zero overlap")
  `AAT_ASSERT_IMPLY(a_trim_shortens, clk, rst, res_valid && res_item.trimmed, res_item.keep_length < res_item.read_length, "trim did not shorten the read")
  `AAT_ASSERT_IMPLY(a_trim_clean, clk, rst, res_valid && res_item.trimmed, !res_item.config_error && !res_item.length_overflow, "trim despite error flag")
  `AAT_ASSERT_IMPLY(a_untrimmed_whole, clk, rst, res_valid && !res_item.trimmed, res_item.keep_length == res_item.read_length && !res_item.matched_adapter, "untrimmed read not kept whole")

endmodule
